// ===== hw/rtl/gidh_pkg.sv =====
package gidh_pkg;
  localparam int SLOTS = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int GID_W = 10;
  localparam int GCNT_W = 11;
  localparam int GROUP_LIMIT = 1024;
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_MULT = 64'h00000100000001B3;
  // FNV_MULT is 2^40 + 0x1B3, so the product is a shift plus a small multiply.
  localparam logic [63:0] FNV_MULT_LO = 64'h00000000000001B3;
  localparam int FNV_MULT_SH = 40;
  localparam logic [63:0] NA_TWEAK = 64'h00000000000000FF;

  localparam logic [1:0] KIND_INT = 2'd0;
  localparam logic [1:0] KIND_DBL = 2'd1;
  localparam logic [1:0] KIND_BOOL = 2'd2;

  localparam logic [0:0] ADDR_KEY_KIND = 1'b0;

  typedef struct packed {
    logic [63:0] key_bits;
    logic key_present;
  } in_item_t;

  typedef struct packed {
    logic [GID_W-1:0] group_id;
    logic is_new;
    logic status;
  } out_item_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [63:0] key_bits;
    logic key_present;
  } job_t;

  typedef enum logic [1:0] {
    H_IDLE, H_RUN, H_DONE
  } hash_state_t;

  typedef enum logic [2:0] {
    P_IDLE, P_READ, P_WAIT, P_CHECK, P_OUT, P_CLEAR
  } probe_state_t;

  function automatic logic dbl_zero(input logic [63:0] b);
    return b[62:0] == 63'd0;
  endfunction

  function automatic logic dbl_nan(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction
endpackage

// ===== hw/rtl/gidh_hash.sv =====
module gidh_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        key_kind,
  input  logic              in_valid,
  output logic              in_ready,
  input  gidh_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output gidh_pkg::job_t    job_data
);
  import gidh_pkg::*;

  hash_state_t state_r, state_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] bits_r, key_r;
  logic present_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] nbytes;
  logic [63:0] mixed;
  logic [63:0] prod;

  // Bytes per key: one for boolean, eight otherwise.
  assign nbytes = (key_kind == KIND_BOOL) ? 4'd1 : 4'd8;
  assign mixed = h_r ^ {56'd0, bits_r[7:0]};
  assign prod = (mixed << FNV_MULT_SH) + mixed * FNV_MULT_LO;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      H_IDLE: if (in_valid) state_nxt = in_data.key_present ? H_RUN : H_DONE;
      H_RUN: if (cnt_r == nbytes - 4'd1) state_nxt = H_DONE;
      H_DONE: if (job_ready) state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  always_comb begin
    h_nxt = h_r;
    cnt_nxt = cnt_r;
    case (state_r)
      H_IDLE: begin
        h_nxt = in_data.key_present ? FNV_BASIS : (FNV_BASIS ^ NA_TWEAK);
        cnt_nxt = 4'd0;
      end
      H_RUN: begin
        h_nxt = prod;
        cnt_nxt = cnt_r + 4'd1;
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == H_IDLE);
  assign job_valid = (state_r == H_DONE);
  assign job_data = '{hash: h_r, key_bits: key_r, key_present: present_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    h_r <= h_nxt;
    cnt_r <= cnt_nxt;
    if (state_r == H_IDLE && in_valid) begin
      key_r <= in_data.key_bits;
      present_r <= in_data.key_present;
      if (key_kind == KIND_BOOL)
        bits_r <= {63'd0, in_data.key_bits[0]};
      else if (key_kind == KIND_DBL && dbl_zero(in_data.key_bits))
        bits_r <= 64'd0;
      else
        bits_r <= in_data.key_bits;
    end else if (state_r == H_RUN) begin
      bits_r <= {8'd0, bits_r[63:8]};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == H_RUN) |-> (cnt_r < nbytes)) else $error("hash byte count overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && !job_ready) |=> (job_valid && $stable(job_data)))
    else $error("job dropped or changed while waiting");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && job_valid)) else $error("input accepted while a job waits");
endmodule

// ===== hw/rtl/gidh_queue.sv =====
module gidh_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  gidh_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output gidh_pkg::job_t rd_data
);
  import gidh_pkg::*;

  job_t mem_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !wr_ready) else $error("full queue accepts a write");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid && !rd_ready) |=> (rd_valid && $stable(rd_data)))
    else $error("queue head changed while waiting");
endmodule

// ===== hw/rtl/gidh_probe.sv =====
module gidh_probe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        key_kind,
  input  logic              job_valid,
  output logic              job_ready,
  input  gidh_pkg::job_t    job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gidh_pkg::out_item_t out_data
);
  import gidh_pkg::*;

  // Each entry carries its own filled bit on top of the slot contents.
  localparam int ENT_W = 1 + GID_W + 64 + 64 + 1;

  probe_state_t state_r, state_nxt;
  logic [ENT_W-1:0] mem [SLOTS];
  logic [ENT_W-1:0] rd_r;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] clr_r;
  logic [SLOT_W:0] tries_r;
  logic [GCNT_W-1:0] gcnt_r;
  job_t job_r;
  out_item_t res_r;
  logic filled_q;
  logic [GID_W-1:0] s_gid;
  logic [63:0] s_hash, s_key;
  logic s_valid, kmatch, wr_en, last;
  logic mem_we;
  logic [SLOT_W-1:0] mem_addr;
  logic [ENT_W-1:0] mem_wdata;

  assign {filled_q, s_gid, s_hash, s_key, s_valid} = rd_r;
  assign idx_nxt = (idx_r == SLOT_W'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign last = tries_r == (SLOT_W+1)'(SLOTS - 1);

  always_comb begin
    if (!s_valid && !job_r.key_present) kmatch = 1'b1;
    else if (!s_valid || !job_r.key_present) kmatch = 1'b0;
    else if (key_kind == KIND_BOOL) kmatch = s_key[0] == job_r.key_bits[0];
    else if (key_kind == KIND_DBL) begin
      if (dbl_nan(s_key) || dbl_nan(job_r.key_bits)) kmatch = 1'b0;
      else if (dbl_zero(s_key) && dbl_zero(job_r.key_bits)) kmatch = 1'b1;
      else kmatch = s_key == job_r.key_bits;
    end else kmatch = s_key == job_r.key_bits;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      P_CLEAR: if (clr_r == SLOT_W'(SLOTS - 1)) state_nxt = P_IDLE;
      P_IDLE: if (job_valid) state_nxt = P_READ;
      P_READ: state_nxt = P_WAIT;
      P_WAIT: state_nxt = P_CHECK;
      P_CHECK: begin
        if (!filled_q || (s_hash == job_r.hash && kmatch) || last) state_nxt = P_OUT;
        else state_nxt = P_READ;
      end
      P_OUT: if (out_ready) state_nxt = P_IDLE;
      default: state_nxt = P_IDLE;
    endcase
  end

  assign wr_en = (state_r == P_CHECK) && !filled_q && (gcnt_r < GCNT_W'(GROUP_LIMIT));
  assign job_ready = state_r == P_IDLE;
  assign out_valid = state_r == P_OUT;
  assign out_data = res_r;

  // One write port, shared by the clearing pass after reset and by inserts.
  assign mem_we = (state_r == P_CLEAR) || wr_en;
  assign mem_addr = (state_r == P_CLEAR) ? clr_r : idx_r;
  assign mem_wdata = (state_r == P_CLEAR) ? '0 :
    {1'b1, gcnt_r[GID_W-1:0], job_r.hash, job_r.key_bits, job_r.key_present};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_CLEAR;
      clr_r <= '0;
      gcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == P_CLEAR) clr_r <= clr_r + 1'b1;
      if (wr_en) gcnt_r <= gcnt_r + 1'b1;
    end
    if (state_r == P_IDLE && job_valid) begin
      job_r <= job_data;
      idx_r <= job_data.hash[SLOT_W-1:0];
      tries_r <= '0;
    end
    if (state_r == P_READ) rd_r <= mem[idx_r];
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (state_r == P_CHECK) begin
      if (!filled_q) begin
        if (wr_en) res_r <= '{group_id: gcnt_r[GID_W-1:0], is_new: 1'b1, status: 1'b0};
        else res_r <= '{group_id: '0, is_new: 1'b0, status: 1'b1};
      end else if (s_hash == job_r.hash && kmatch) begin
        res_r <= '{group_id: s_gid, is_new: 1'b0, status: 1'b0};
      end else begin
        res_r <= '{group_id: '0, is_new: 1'b0, status: 1'b1};
        idx_r <= idx_nxt;
        tries_r <= tries_r + 1'b1;
      end
    end
  end

  a_gcnt: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= GCNT_W'(GROUP_LIMIT)) else $error("group count overrun");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !filled_q) else $error("write to filled slot");
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(res_r.is_new && res_r.status)) else $error("bad result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_r)))
    else $error("result changed while waiting");
endmodule

// ===== hw/rtl/group_id_hash_table.sv =====
// Group id hash table: each key gets a dense group id through FNV-1a hashing and a
// linear probe over 1024 slots. The hasher takes the key one byte at a time (eight
// bytes, or one for boolean keys; NA keys skip hashing), and each probed slot passes
// through the read, wait and check states, as the read of the slot memory is
// registered. The hasher and the prober run decoupled through a two-entry queue.
// After reset the prober clears the slot table before it takes its first key.
// Write key_kind only while idle.
module group_id_hash_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gidh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gidh_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import gidh_pkg::*;

  logic [1:0] kind_r;
  logic hj_valid, hj_ready, qj_valid, qj_ready;
  job_t hj_data, qj_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ADDR_KEY_KIND) ? {30'd0, kind_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= KIND_INT;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == ADDR_KEY_KIND)
      kind_r <= cfg_pwdata[1:0];
  end

  gidh_hash u_hash (.clk, .rst_n, .key_kind(kind_r), .in_valid, .in_ready, .in_data,
    .job_valid(hj_valid), .job_ready(hj_ready), .job_data(hj_data));
  gidh_queue u_queue (.clk, .rst_n, .wr_valid(hj_valid), .wr_ready(hj_ready),
    .wr_data(hj_data), .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj_data));
  gidh_probe u_probe (.clk, .rst_n, .key_kind(kind_r), .job_valid(qj_valid),
    .job_ready(qj_ready), .job_data(qj_data), .out_valid, .out_ready, .out_data);
endmodule

// ===== sim/gidh_checker.sv =====
`timescale 1ns / 100ps

module gidh_checker
  import gidh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);

  logic              tab_filled [SLOTS];
  logic [GID_W-1:0]  tab_group  [SLOTS];
  logic [63:0]       tab_hash   [SLOTS];
  logic [63:0]       tab_key    [SLOTS];
  logic              tab_present[SLOTS];
  logic [GCNT_W-1:0] next_gid;
  logic [1:0]        cur_kind;
  out_item_t         expected_ids[$];

  function automatic logic [63:0] fnv_hash(input logic [63:0] bits, input logic present);
    logic [63:0] h;
    h = FNV_BASIS;
    if (!present) return FNV_BASIS ^ NA_TWEAK;
    if (cur_kind == KIND_BOOL) begin
      h = (h ^ {63'd0, bits[0]}) * FNV_MULT;
      return h;
    end
    // Negative zero hashes like positive zero.
    if (cur_kind == KIND_DBL && bits[62:0] == 63'd0) bits = 64'd0;
    for (int n = 0; n < 8; n++) h = (h ^ {56'd0, bits[8*n +: 8]}) * FNV_MULT;
    return h;
  endfunction

  function automatic logic is_nan(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic same_key(input logic [63:0] sk, input logic sp,
                                    input logic [63:0] k, input logic p);
    if (!sp && !p) return 1'b1;
    if (!sp || !p) return 1'b0;
    if (cur_kind == KIND_BOOL) return sk[0] == k[0];
    if (cur_kind == KIND_DBL) begin
      if (is_nan(sk) || is_nan(k)) return 1'b0;
      if (sk[62:0] == 63'd0 && k[62:0] == 63'd0) return 1'b1;
    end
    return sk == k;
  endfunction

  function automatic out_item_t lookup_or_insert(input in_item_t it);
    logic [63:0] h;
    logic [SLOT_W-1:0] idx;
    out_item_t r;
    h = fnv_hash(it.key_bits, it.key_present);
    idx = h[SLOT_W-1:0];
    for (int n = 0; n < SLOTS; n++) begin
      if (!tab_filled[idx]) begin
        if (next_gid >= GROUP_LIMIT) break;
        tab_filled[idx] = 1'b1;
        tab_group[idx] = next_gid[GID_W-1:0];
        tab_hash[idx] = h;
        tab_key[idx] = it.key_bits;
        tab_present[idx] = it.key_present;
        r.group_id = next_gid[GID_W-1:0];
        r.is_new = 1'b1;
        r.status = 1'b0;
        next_gid = next_gid + 1'b1;
        return r;
      end
      if (tab_hash[idx] == h &&
          same_key(tab_key[idx], tab_present[idx], it.key_bits, it.key_present)) begin
        r.group_id = tab_group[idx];
        r.is_new = 1'b0;
        r.status = 1'b0;
        return r;
      end
      idx = idx + 1'b1;
    end
    r.group_id = '0;
    r.is_new = 1'b0;
    r.status = 1'b1;
    return r;
  endfunction

  initial begin
    errors = 0;
    next_gid = '0;
    cur_kind = KIND_INT;
    for (int i = 0; i < SLOTS; i++) tab_filled[i] = 1'b0;
  end

  assign pending = expected_ids.size();

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {ADDR_KEY_KIND, 2'b00})
        cur_kind = cfg_pwdata[1:0];
      if (out_valid && out_ready) begin
        if (expected_ids.size() == 0) begin
          $display("%0t: unexpected transaction, actual %p", $time, out_data);
          errors++;
        end else begin
          exp_r = expected_ids.pop_front();
          if (out_data.group_id !== exp_r.group_id) begin
            $display("%0t: group_id mismatch, expected %0d, actual %0d",
                     $time, exp_r.group_id, out_data.group_id);
            errors++;
          end
          if (out_data.is_new !== exp_r.is_new) begin
            $display("%0t: is_new mismatch, expected %0b, actual %0b",
                     $time, exp_r.is_new, out_data.is_new);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $display("%0t: status mismatch, expected %0b, actual %0b",
                     $time, exp_r.status, out_data.status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) expected_ids.push_back(lookup_or_insert(in_data));
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gidh_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_item_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors, pending;
  bit          quiet = 1'b0;
  bit          want_hold = 1'b0;
  logic [63:0] key_pool[$];
  logic [1:0]  kind_now;

  always #2 clk = ~clk;

  group_id_hash_table DUT (.*);

  gidh_checker u_checker (.*);

  task automatic send_key(input logic [63:0] k, input logic p);
    in_valid <= 1'b1;
    in_data <= '{key_bits: k, key_present: p};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop offering keys and wait until every transaction has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_kind(input logic [1:0] kind);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {ADDR_KEY_KIND, 2'b00};
    cfg_pwdata <= ({$urandom} & 32'hFFFF_FFFC) | {30'd0, kind};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    kind_now = kind;
  endtask

  task automatic send_random();
    logic [63:0] k;
    int pick;
    pick = $urandom_range(0, 99);
    k = {$urandom, $urandom};
    if (pick < 10) begin
      send_key(k, 1'b0);
      return;
    end
    if (pick < 50 && key_pool.size() != 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (pick < 70 && kind_now == KIND_DBL) begin
      case ($urandom_range(0, 3))
        0: k = {k[63], 63'd0};
        1: k = {k[63], 11'h7FF, k[51:1], 1'b1};
        2: k = {k[63], 11'h7FF, 52'd0};
        default: k = {k[63:52], 52'd0};
      endcase
    end
    if (key_pool.size() < 200) key_pool.push_back(k);
    send_key(k, 1'b1);
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        want_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int wait_cnt;
    kind_now = KIND_INT;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Integer extremes, repeats and missing keys.
    send_key(64'd0, 1'b1);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_key(64'h8000_0000_0000_0000, 1'b1);
    send_key(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_key(64'h0123_4567_89AB_CDEF, 1'b0);
    send_key(64'd0, 1'b0);
    drain();
    // Doubles: signed zeros meet, every NaN opens a group.
    write_kind(KIND_DBL);
    send_key(64'h0000_0000_0000_0000, 1'b1);
    send_key(64'h8000_0000_0000_0000, 1'b1);
    send_key(64'h7FF8_0000_0000_0000, 1'b1);
    send_key(64'h7FF8_0000_0000_0000, 1'b1);
    send_key(64'hFFF0_0000_0000_0001, 1'b1);
    send_key(64'h7FF0_0000_0000_0000, 1'b1);
    send_key(64'hFFF0_0000_0000_0000, 1'b1);
    send_key(64'h3FF0_0000_0000_0000, 1'b1);
    send_key(64'd5, 1'b0);
    drain();
    // Booleans ignore the upper bits.
    write_kind(KIND_BOOL);
    send_key(64'd0, 1'b1);
    send_key(64'd1, 1'b1);
    send_key(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_key(64'd0, 1'b0);
    drain();
    // The undefined kind behaves as integer.
    write_kind(2'd3);
    send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_key(64'd1, 1'b1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_kind(ph == 4 ? KIND_DBL : ph[1:0]);
      key_pool.delete();
      if (ph == 1) want_hold = 1'b1;
      for (int i = 0; i < 110; i++) send_random();
      drain();
    end

    // Last part: back to back with no idling on either side.
    quiet = 1'b1;
    write_kind(KIND_INT);
    key_pool.delete();
    for (int i = 0; i < 150; i++) send_random();
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS group_id_hash_table");
    end else begin
      $display("FAIL group_id_hash_table");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL group_id_hash_table");
    $finish;
  end

endmodule

// ===== group_id_hash_table.f =====
hw/rtl/gidh_pkg.sv
hw/rtl/gidh_hash.sv
hw/rtl/gidh_queue.sv
hw/rtl/gidh_probe.sv
hw/rtl/group_id_hash_table.sv
sim/gidh_checker.sv
sim/tb_top.sv
